@@ hw/rtl/keypad_matrix_change_events_unit_assert.svh @@
// Assertion helpers for the keypad change-event unit.
// Both expect aclk and aresetn in scope.
`ifndef KEYPAD_MATRIX_CHANGE_EVENTS_UNIT_ASSERT_SVH
`define KEYPAD_MATRIX_CHANGE_EVENTS_UNIT_ASSERT_SVH

// Same-cycle implication.
`define KMCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KMCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/kmce_pkg.sv @@
package kmce_pkg;

    localparam int NUM_KEYS        = 16;
    localparam int NUM_COLUMNS     = 8;
    localparam int ROWS_PER_COLUMN = 8;
    localparam int POS_STRIDE      = 8;
    localparam int KEY_W           = 4;
    localparam int CODE_W          = 9;
    localparam int IDLE_W          = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    // Register indices
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MAP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_VALID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_BIAS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT   = 3'd4;

    localparam logic [7:0]        PRESS_OFFSET_RST = 8'd16;
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST   = 3'd5;

    // Queue between front and back
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    typedef struct packed {
        logic [63:0] matrix_bits;
        logic        key_int_pending;
    } in_t;

    typedef struct packed {
        logic              has_event;
        logic [CODE_W-1:0] event_code;
        logic              is_press;
        logic              scan_stop;
        logic              last;
    } out_t;

    typedef struct packed {
        logic [NUM_KEYS*KEY_W-1:0] key_map;
        logic [NUM_KEYS-1:0]       key_valid;
        logic [7:0]                press_offset;
        logic                      event_bias;
        logic [IDLE_W-1:0]         idle_limit;
    } cfg_t;

    // One classified scan
    typedef struct packed {
        logic [NUM_KEYS-1:0] changed;
        logic [NUM_KEYS-1:0] fresh;
        logic                stop;
    } job_t;

endpackage

@@ hw/rtl/kmce_front.sv @@
module kmce_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  kmce_pkg::cfg_t   cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  kmce_pkg::in_t    s_data,
    input  logic             q_full,
    output logic             q_push,
    output kmce_pkg::job_t   q_job
);

    logic [kmce_pkg::NUM_KEYS-1:0] flags_reg, flags_next;
    logic [kmce_pkg::IDLE_W-1:0]   idle_reg, idle_next;
    logic [kmce_pkg::NUM_KEYS-1:0] fresh;
    logic [kmce_pkg::IDLE_W-1:0]   idle_inc;
    logic                          stop;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // Rebuild key-down flags from the mapped positions
    always_comb begin
        logic [kmce_pkg::KEY_W-1:0] idx;
        fresh = '0;
        idx   = '0;
        for (int p = 0; p < kmce_pkg::NUM_KEYS; p++) begin
            idx = cfg.key_map[p*kmce_pkg::KEY_W +: kmce_pkg::KEY_W];
            if ((p / kmce_pkg::POS_STRIDE) < kmce_pkg::NUM_COLUMNS &&
                (p % kmce_pkg::POS_STRIDE) < kmce_pkg::ROWS_PER_COLUMN &&
                s_data.matrix_bits[p] && cfg.key_valid[p] &&
                int'(idx) < kmce_pkg::NUM_KEYS) begin
                fresh[idx] = 1'b1;
            end
        end
    end

    // Idle scan counter
    always_comb begin
        idle_inc  = idle_reg + kmce_pkg::IDLE_W'(1);
        stop      = 1'b0;
        idle_next = idle_inc;
        if (s_data.key_int_pending) begin
            idle_next = '0;
        end else if (idle_inc == cfg.idle_limit) begin
            stop      = 1'b1;
            idle_next = '0;
        end
    end

    assign flags_next    = fresh;
    assign q_job.changed = fresh ^ flags_reg;
    assign q_job.fresh   = fresh;
    assign q_job.stop    = stop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
            idle_reg  <= '0;
        end else if (q_push) begin
            flags_reg <= flags_next;
            idle_reg  <= idle_next;
        end
    end

endmodule

@@ hw/rtl/kmce_queue.sv @@
module kmce_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  kmce_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output kmce_pkg::job_t pop_job
);

    kmce_pkg::job_t                mem_reg [kmce_pkg::QUEUE_DEPTH];
    logic [kmce_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [kmce_pkg::QUEUE_AW:0]   count_reg, count_next;

    assign full      = (count_reg == (kmce_pkg::QUEUE_AW+1)'(kmce_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (kmce_pkg::QUEUE_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (kmce_pkg::QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + kmce_pkg::QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + kmce_pkg::QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/kmce_back.sv @@
`include "keypad_matrix_change_events_unit_assert.svh"

module kmce_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  kmce_pkg::cfg_t cfg,
    input  logic           q_valid,
    input  kmce_pkg::job_t q_job,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output kmce_pkg::out_t m_data
);

    logic                          busy_reg;
    logic [kmce_pkg::NUM_KEYS-1:0] rem_reg, rem_next;
    logic [kmce_pkg::NUM_KEYS-1:0] fresh_reg;
    logic                          stop_reg;
    logic                          out_valid_reg;
    kmce_pkg::out_t                out_reg, out_next;

    logic                          load, advance, last_evt;
    logic [kmce_pkg::NUM_KEYS-1:0] low_bit;
    logic [kmce_pkg::KEY_W-1:0]    key;
    logic                          press;

    assign load    = !busy_reg && q_valid;
    assign q_pop   = load;
    assign advance = busy_reg && (!out_valid_reg || m_ready);

    // Lowest pending changed key
    assign low_bit = rem_reg & (~rem_reg + kmce_pkg::NUM_KEYS'(1));
    always_comb begin
        key = '0;
        for (int k = 0; k < kmce_pkg::NUM_KEYS; k++) begin
            if (low_bit[k]) begin
                key = key | kmce_pkg::KEY_W'(k);
            end
        end
    end

    assign rem_next = rem_reg & ~low_bit;
    assign last_evt = (rem_next == '0);
    assign press    = |(fresh_reg & low_bit);

    always_comb begin
        out_next            = '0;
        out_next.last       = last_evt;
        out_next.scan_stop  = last_evt && stop_reg;
        if (rem_reg != '0) begin
            out_next.has_event  = 1'b1;
            out_next.is_press   = press;
            out_next.event_code = kmce_pkg::CODE_W'(key)
                                + (press ? kmce_pkg::CODE_W'(cfg.press_offset)
                                         : kmce_pkg::CODE_W'(0))
                                + kmce_pkg::CODE_W'(cfg.event_bias);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
            end else if (advance && last_evt) begin
                busy_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg   <= q_job.changed;
            fresh_reg <= q_job.fresh;
            stop_reg  <= q_job.stop;
        end else if (advance) begin
            rem_reg <= rem_next;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `KMCE_ASSERT_NOW(a_stop_on_last, out_valid_reg && !out_reg.last, !out_reg.scan_stop, "scan_stop on a beat that is not last")
    `KMCE_ASSERT_NOW(a_empty_beat, out_valid_reg && !out_reg.has_event, out_reg.last && out_reg.event_code == '0 && !out_reg.is_press, "no-change beat malformed")
    `KMCE_ASSERT_NEXT(a_load_busy, load, busy_reg, "scan loaded but back end idle")
    `KMCE_ASSERT_NEXT(a_last_frees, advance && last_evt, !busy_reg, "back end still busy after last beat")

endmodule

@@ hw/rtl/keypad_matrix_change_events_unit.sv @@
// Keypad change-event unit. Each s_ beat is one debounced 8x8 matrix scan plus the
// key-interrupt pending flag; positions 0..15 map through key_map/key_valid to key
// indices, and every key whose down state differs from the previous scan gives
// one m_ beat, lowest key first (press: key + press_offset, release: key, both
// + event_bias). A scan with no change gives one beat with has_event low. The
// final beat of a scan carries last, and scan_stop when idle_limit scans in a row
// showed no pending interrupt (a limit of 0 stops after eight). The front end
// classifies a scan in the cycle it is accepted and takes one per cycle while
// its two-entry queue has room; the back end loads one scan at a time, gives
// its beats in turn while the output accepts them, and takes the next scan
// only once the final beat of the last one is in its output register.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once
// and should only be made with no scan in flight.
module keypad_matrix_change_events_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  kmce_pkg::in_t                      s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output kmce_pkg::out_t                     m_data,
    input  logic                               cfg_wr_en,
    input  logic [kmce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kmce_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // Configuration registers
    kmce_pkg::cfg_t cfg_reg;

    // Front to queue, queue to back
    logic           q_push, q_full, q_pop, q_valid;
    kmce_pkg::job_t push_job, pop_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.key_map      <= '0;
            cfg_reg.key_valid    <= '0;
            cfg_reg.press_offset <= kmce_pkg::PRESS_OFFSET_RST;
            cfg_reg.event_bias   <= 1'b0;
            cfg_reg.idle_limit   <= kmce_pkg::IDLE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                kmce_pkg::REG_KEY_MAP: begin
                    cfg_reg.key_map <= cfg_wdata[kmce_pkg::NUM_KEYS*kmce_pkg::KEY_W-1:0];
                end
                kmce_pkg::REG_KEY_VALID: begin
                    cfg_reg.key_valid <= cfg_wdata[kmce_pkg::NUM_KEYS-1:0];
                end
                kmce_pkg::REG_PRESS_OFFSET: begin
                    cfg_reg.press_offset <= cfg_wdata[7:0];
                end
                kmce_pkg::REG_EVENT_BIAS: begin
                    cfg_reg.event_bias <= cfg_wdata[0];
                end
                kmce_pkg::REG_IDLE_LIMIT: begin
                    cfg_reg.idle_limit <= cfg_wdata[kmce_pkg::IDLE_W-1:0];
                end
                default: begin
                    // unused index: write dropped
                end
            endcase
        end
    end

    // Front end: builds key flags, idle count, changed mask
    kmce_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (push_job)
    );

    // Short queue so front and back stall independently
    kmce_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_job   (pop_job)
    );

    // Back end: one event beat per changed key (one quiet beat if none), registered output
    kmce_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_job   (pop_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ tb/keypad_matrix_change_events_unit_tb.sv @@
`timescale 1ns / 1ps

module keypad_matrix_change_events_unit_tb;

    import kmce_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_GAP       = 17;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_SCANS   = 80;
    localparam int SETTLE_CYCLES = 20;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_KEY_MAP;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor's copy of the registers, as they stand after reset
    logic [63:0]       map_cfg    = '0;
    logic [15:0]       valid_cfg  = '0;
    logic [7:0]        offset_cfg = PRESS_OFFSET_RST;
    logic              bias_cfg   = 1'b0;
    logic [IDLE_W-1:0] limit_cfg  = IDLE_LIMIT_RST;

    // Predictor's copy of the block state
    logic [NUM_KEYS-1:0] pred_key_down = '0;
    logic [IDLE_W-1:0]   pred_idle     = '0;

    out_t expected_key_events[$];

    // Idling control for the sender (tx_) and the receiver (rx_)
    int tx_max_gap    = MAX_GAP;
    int rx_max_gap    = MAX_GAP;
    int rx_long_hold  = 0;

    int mismatch_count     = 0;
    int scans_sent         = 0;
    int press_seen         = 0;
    int release_seen       = 0;
    int quiet_seen         = 0;
    int stop_seen          = 0;
    int input_stall_cycles = 0;
    int cycle_count        = 0;

    keypad_matrix_change_events_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog, plus a count of cycles where the block refuses a scan
    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn && s_valid && !s_ready)
            input_stall_cycles++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: works out the event beats for one accepted scan and
    // queues them. Only matrix positions 0..15 (column 0 and 1) can map
    // to a key; everything above is simply ignored.
    // ------------------------------------------------------------------
    task automatic predict_key_events(input in_t scan);
        logic [NUM_KEYS-1:0] fresh;
        logic [NUM_KEYS-1:0] changed;
        logic                stop;
        out_t                ev;
        int                  total;
        int                  seen;
        int                  p;
        int                  k;
        fresh = '0;
        for (p = 0; p < NUM_KEYS; p++)
            if (scan.matrix_bits[p] && valid_cfg[p])
                fresh[map_cfg[4*p +: 4]] = 1'b1;

        // Idle run: a pending interrupt clears it, the limit stops scanning
        stop = 1'b0;
        if (scan.key_int_pending) begin
            pred_idle = '0;
        end else begin
            pred_idle = pred_idle + 3'd1;
            if (pred_idle == limit_cfg) begin
                stop      = 1'b1;
                pred_idle = '0;
            end
        end

        changed = fresh ^ pred_key_down;
        total   = $countones(changed);
        seen    = 0;
        for (k = 0; k < NUM_KEYS; k++) begin
            if (changed[k]) begin
                seen++;
                ev.has_event  = 1'b1;
                ev.is_press   = fresh[k];
                ev.event_code = 9'(k) + (fresh[k] ? {1'b0, offset_cfg} : 9'd0)
                              + {8'd0, bias_cfg};
                ev.last       = (seen == total);
                ev.scan_stop  = ev.last & stop;
                expected_key_events.push_back(ev);
            end
        end
        // Nothing changed: a single quiet beat still closes the scan
        if (total == 0) begin
            ev           = '0;
            ev.last      = 1'b1;
            ev.scan_stop = stop;
            expected_key_events.push_back(ev);
        end
        pred_key_down = fresh;
    endtask

    // ------------------------------------------------------------------
    // Register writes, only ever made with the block idle
    // ------------------------------------------------------------------
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [63:0] map, input logic [15:0] valid,
                             input logic [7:0] offset, input logic bias,
                             input logic [IDLE_W-1:0] limit);
        put_reg(REG_KEY_MAP, map);
        put_reg(REG_KEY_VALID, {48'd0, valid});
        put_reg(REG_PRESS_OFFSET, {56'd0, offset});
        put_reg(REG_EVENT_BIAS, {63'd0, bias});
        put_reg(REG_IDLE_LIMIT, {61'd0, limit});
        cfg_wr_en  <= 1'b0;
        map_cfg    = map;
        valid_cfg  = valid;
        offset_cfg = offset;
        bias_cfg   = bias;
        limit_cfg  = limit;
    endtask

    // ------------------------------------------------------------------
    // Sender: one scan beat. Valid is left high on return so that a
    // back-to-back beat never lowers and raises it in the same step.
    // ------------------------------------------------------------------
    task automatic send_scan(input logic [63:0] matrix, input logic pending);
        in_t beat;
        int  gap;
        beat.matrix_bits     = matrix;
        beat.key_int_pending = pending;
        gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_key_events(beat);
        scans_sent++;
    endtask

    // Stop offering scans and wait for every queued event beat
    task automatic drain_events();
        s_valid <= 1'b0;
        while (expected_key_events.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------
    task automatic flag_field(input string field, input logic [8:0] want,
                              input logic [8:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        mismatch_count++;
    endtask

    task automatic check_event(input out_t got);
        out_t want;
        if (expected_key_events.size() == 0) begin
            $display("%0t: event beat with none expected, expected nothing, got %p",
                     $time, got);
            mismatch_count++;
        end else begin
            want = expected_key_events.pop_front();
            if (got.has_event !== want.has_event)
                flag_field("has_event", 9'(want.has_event), 9'(got.has_event));
            if (got.event_code !== want.event_code)
                flag_field("event_code", want.event_code, got.event_code);
            if (got.is_press !== want.is_press)
                flag_field("is_press", 9'(want.is_press), 9'(got.is_press));
            if (got.scan_stop !== want.scan_stop)
                flag_field("scan_stop", 9'(want.scan_stop), 9'(got.scan_stop));
            if (got.last !== want.last)
                flag_field("last", 9'(want.last), 9'(got.last));
            if (!want.has_event)
                quiet_seen++;
            else if (want.is_press)
                press_seen++;
            else
                release_seen++;
            if (want.scan_stop)
                stop_seen++;
        end
    endtask

    initial begin : event_sink
        int hold;
        wait (aresetn === 1'b1);
        forever begin
            // A requested long hold-off takes the place of the usual draw
            if (rx_long_hold > 0) begin
                hold         = rx_long_hold;
                rx_long_hold = 0;
            end else begin
                hold = (rx_max_gap == 0) ? 0 : $urandom_range(0, rx_max_gap);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            check_event(m_data);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at reset: no position is valid, so every scan is quiet;
    // idle limit of five, broken once by a pending interrupt.
    task automatic test_reset_defaults();
        int i;
        send_scan(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_scan(64'h0, 1'b1);
        for (i = 0; i < 5; i++)
            send_scan({$urandom, $urandom}, 1'b0);
        drain_events();
    endtask

    // Identity map: sixteen presses in one scan, a repeat with no change,
    // then all released while the unmapped upper positions are set.
    task automatic test_identity_map();
        configure(64'hFEDC_BA98_7654_3210, 16'hFFFF, 8'd16, 1'b0, 3'd7);
        send_scan(64'h0000_0000_0000_FFFF, 1'b1);
        send_scan(64'h0000_0000_0000_FFFF, 1'b1);
        send_scan(64'hFFFF_FFFF_FFFF_0000, 1'b0);
        send_scan(64'h0000_0000_0000_A5A5, 1'b0);
        drain_events();
    endtask

    // Every position onto key 15, half the positions invalid, largest
    // offset with bias (top code), idle limit of one.
    task automatic test_code_extremes();
        configure(64'hFFFF_FFFF_FFFF_FFFF, 16'h5555, 8'd255, 1'b1, 3'd1);
        send_scan(64'h2, 1'b0);
        send_scan(64'h1, 1'b0);
        send_scan(64'hFFFF, 1'b1);
        send_scan(64'h0, 1'b0);
        drain_events();
    endtask

    // Limit of zero: the counter has to wrap, stop after eight idle scans
    task automatic test_idle_limit_zero();
        int i;
        configure(64'h0123_4567_89AB_CDEF, 16'hFFFF, 8'd0, 1'b0, 3'd0);
        send_scan(64'h8001, 1'b1);
        for (i = 0; i < 8; i++)
            send_scan({$urandom, $urandom}, 1'b0);
        drain_events();
    endtask

    // Receiver goes quiet for a long stretch while full scans keep coming,
    // so the internal queue fills and the input beat is held off.
    task automatic test_output_backpressure();
        int i;
        configure(64'hFEDC_BA98_7654_3210, 16'hFFFF, 8'd100, 1'b0, 3'd3);
        tx_max_gap   = 0;
        rx_long_hold = LONG_HOLD;
        for (i = 0; i < 12; i++)
            send_scan(i[0] ? 64'h0 : 64'hFFFF, i[1]);
        drain_events();
        tx_max_gap = MAX_GAP;
    endtask

    // Random phases: fresh registers each phase, scans evolving from the
    // previous matrix so that no-change, few-change and many-change
    // scans all turn up; pending kept rare enough to reach stops.
    task automatic test_random_scans();
        logic [63:0] matrix;
        logic [7:0]  offset;
        int          phase;
        int          i;
        matrix = '0;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 2))
                0:       offset = 8'd0;
                1:       offset = 8'd255;
                default: offset = 8'($urandom);
            endcase
            configure({$urandom, $urandom}, 16'($urandom | $urandom), offset,
                      1'($urandom), 3'($urandom));
            tx_max_gap = $urandom_range(0, 2) == 0 ? 0 : MAX_GAP;
            rx_max_gap = $urandom_range(0, 2) == 0 ? 0 : MAX_GAP;
            for (i = 0; i < PHASE_SCANS; i++) begin
                case ($urandom_range(0, 9))
                    0, 1: ;
                    2, 3, 4: begin
                        matrix[$urandom_range(0, 15)] ^= 1'b1;
                        matrix[$urandom_range(0, 15)] ^= 1'b1;
                    end
                    5:       matrix[15:0] = ~matrix[15:0];
                    6:       matrix[63:16] = {$urandom, 16'($urandom)};
                    default: matrix = {$urandom, $urandom};
                endcase
                send_scan(matrix, $urandom_range(0, 3) == 0);
            end
            drain_events();
        end
        tx_max_gap = MAX_GAP;
        rx_max_gap = MAX_GAP;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_identity_map();
        test_code_extremes();
        test_idle_limit_zero();
        test_output_backpressure();
        test_random_scans();

        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d scans: %0d presses, %0d releases, %0d quiet scans, %0d stops",
                 scans_sent, press_seen, release_seen, quiet_seen, stop_seen);
        $display("Input held off for %0d cycles under output back-pressure",
                 input_stall_cycles);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/kmce_pkg.sv
hw/rtl/kmce_front.sv
hw/rtl/kmce_queue.sv
hw/rtl/kmce_back.sv
hw/rtl/keypad_matrix_change_events_unit.sv
tb/keypad_matrix_change_events_unit_tb.sv
